@@ src/two_coloring_check_by_scc_macros.svh @@
// Assertion macros used by the checker file.
`ifndef TWO_COLORING_CHECK_BY_SCC_MACROS_SVH
`define TWO_COLORING_CHECK_BY_SCC_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TCC_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcc check failed");
// Next-cycle implication checked outside reset.
`define TCC_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcc check failed");
`endif

@@ src/tcc_pkg.sv @@
// Package: shared types and constants of the two-coloring check.
`default_nettype none
package tcc_pkg;
	localparam int FIELD_W = 12;

	// Walk sequencer states
	localparam logic [4:0] ST_LOAD  = 5'd0;
	localparam logic [4:0] ST_ARCR  = 5'd1;
	localparam logic [4:0] ST_ARCW  = 5'd2;
	localparam logic [4:0] ST_SCAN  = 5'd3;
	localparam logic [4:0] ST_SCANR = 5'd4;
	localparam logic [4:0] ST_STEP  = 5'd5;
	localparam logic [4:0] ST_ARCD  = 5'd6;
	localparam logic [4:0] ST_TGT   = 5'd7;
	localparam logic [4:0] ST_FIN   = 5'd8;
	localparam logic [4:0] ST_POPR  = 5'd9;
	localparam logic [4:0] ST_POPW  = 5'd10;
	localparam logic [4:0] ST_RET   = 5'd11;
	localparam logic [4:0] ST_REST  = 5'd12;
	localparam logic [4:0] ST_CHK   = 5'd13;
	localparam logic [4:0] ST_CHKR  = 5'd14;
	localparam logic [4:0] ST_OUT   = 5'd15;
	localparam logic [4:0] ST_CLR   = 5'd16;

	// Status handed from the engine to the output stage
	typedef struct packed {
		logic done;
		logic conflict;
		logic overflow;
	} tcc_status_t;
endpackage
`default_nettype wire

@@ src/tcc_engine.sv @@
// Engine: arc store, node tables, stacks and the Tarjan walk sequencer.
`default_nettype none
module tcc_engine import tcc_pkg::*; #(
	parameter int MAX_VERTICES = 2048,
	parameter int MAX_EDGES = 16384
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [FIELD_W-1:0]  va,
	input  wire logic [FIELD_W-1:0]  vb,
	input  wire logic                ev,
	input  wire logic                lst,
	input  wire logic [FIELD_W-1:0]  vcount,
	output logic                     busy,
	output tcc_status_t              status
);
	localparam int NODES = 2 * MAX_VERTICES + 1;
	localparam int NW0 = $clog2(NODES + 1);
	localparam int NW = (NW0 > FIELD_W) ? NW0 : FIELD_W + 1;
	localparam int NIW = $clog2(NODES);
	localparam int ARCS = 4 * MAX_EDGES;
	localparam int AW = $clog2(ARCS + 1);
	localparam int AIW = $clog2(ARCS);
	localparam logic [NW-1:0] NMAX = NW'(MAX_VERTICES);
	localparam logic [NW-1:0] NLAST = NW'(NODES - 1);
	localparam logic [AW-1:0] ALIM = AW'(ARCS - 4);

	// Memories
	logic [NW-1:0] arc_target [ARCS];
	logic [AW-1:0] arc_link   [ARCS];
	logic [AW-1:0] list_head  [NODES];
	logic [NW-1:0] visit_time [NODES];
	logic [NW-1:0] comp_id    [NODES];
	logic [NW-1:0] node_stack [NODES];
	logic [NW-1:0] call_node  [NODES];
	logic [AW-1:0] call_arc   [NODES];
	logic [NW-1:0] call_low   [NODES];

	// Sequencer registers; v_q/ca_q/low_q cache the top call frame
	logic [4:0]    state_q;
	logic [1:0]    k_q;
	logic          lst_q, ovf_q, conf_q;
	logic [NW-1:0] n_q, a_q, b_q, i_q, v_q, t_q, low_q, tm_q, cc_q, nst_q, cst_q;
	logic [AW-1:0] arc_cnt_q, ca_q;

	// Registered read data
	logic [NW-1:0] rd_tgt_q, rd_vt_q, rd_cid_q, rd_cid2_q, rd_ns_q, rd_cn_q, rd_cl_q;
	logic [AW-1:0] rd_lnk_q, rd_lh_q, rd_ca_q;

	logic [NW-1:0] neff;
	always_comb begin
		neff = {{(NW-FIELD_W){1'b0}}, vcount};
		if (vcount == '0) neff = NW'(1);
		if (neff > NMAX) neff = NMAX;
	end

	logic [NW-1:0] two_n;
	assign two_n = n_q << 1;
	logic [NW-1:0] ext_a, ext_b;
	assign ext_a = {{(NW-FIELD_W){1'b0}}, va};
	assign ext_b = {{(NW-FIELD_W){1'b0}}, vb};
	logic edge_ok;
	assign edge_ok = ev && ext_a != '0 && ext_b != '0 && ext_a <= neff && ext_b <= neff;

	// Source and target of the arc being loaded
	logic [NW-1:0] from_node, to_node;
	always_comb begin
		case (k_q)
			2'd0: begin from_node = a_q + n_q; to_node = b_q; end
			2'd1: begin from_node = b_q + n_q; to_node = a_q; end
			2'd2: begin from_node = a_q; to_node = b_q + n_q; end
			default: begin from_node = b_q; to_node = a_q + n_q; end
		endcase
	end

	// Node table read address
	logic [NW-1:0] node_ra;
	always_comb begin
		case (state_q)
			ST_ARCR: node_ra = from_node;
			ST_ARCD: node_ra = rd_tgt_q;
			ST_STEP: node_ra = v_q;
			default: node_ra = i_q;
		endcase
	end

	// Node entry: root from the scan or unvisited arc target
	logic tgt_ok, enter_root, enter_child, enter_node;
	logic [NW-1:0] new_node;
	assign tgt_ok = (t_q != '0) && (t_q <= two_n) && (rd_cid_q == '0);
	assign enter_root = (state_q == ST_SCANR) && (rd_vt_q == '0);
	assign enter_child = (state_q == ST_TGT) && tgt_ok && (rd_vt_q == '0);
	assign enter_node = enter_root || enter_child;
	assign new_node = (state_q == ST_TGT) ? t_q : i_q;

	assign busy = (state_q != ST_LOAD);
	assign status.done = (state_q == ST_OUT);
	assign status.conflict = conf_q;
	assign status.overflow = ovf_q;

	// Memory writes
	always_ff @(posedge clk) begin
		if (state_q == ST_ARCW) begin
			arc_target[AIW'(arc_cnt_q)] <= to_node;
			arc_link[AIW'(arc_cnt_q)] <= rd_lh_q;
		end
		if (state_q == ST_ARCW) list_head[NIW'(from_node)] <= arc_cnt_q + AW'(1);
		else if (state_q == ST_CLR) list_head[NIW'(i_q)] <= '0;
		if (enter_node) visit_time[NIW'(new_node)] <= tm_q;
		else if (state_q == ST_CLR) visit_time[NIW'(i_q)] <= '0;
		if (state_q == ST_POPW) comp_id[NIW'(rd_ns_q)] <= cc_q;
		else if (state_q == ST_CLR) comp_id[NIW'(i_q)] <= '0;
		if (enter_node) node_stack[NIW'(nst_q)] <= new_node;
		// spill the current top frame when a child is entered
		if (enter_child) begin
			call_node[NIW'(cst_q - NW'(1))] <= v_q;
			call_arc[NIW'(cst_q - NW'(1))] <= ca_q;
			call_low[NIW'(cst_q - NW'(1))] <= low_q;
		end
	end

	// Memory reads, registered
	always_ff @(posedge clk) begin
		rd_lh_q   <= list_head[NIW'(node_ra)];
		rd_vt_q   <= visit_time[NIW'(node_ra)];
		rd_cid_q  <= comp_id[NIW'(node_ra)];
		rd_cid2_q <= comp_id[NIW'(i_q + n_q)];
		rd_tgt_q  <= arc_target[AIW'(ca_q - AW'(1))];
		rd_lnk_q  <= arc_link[AIW'(ca_q - AW'(1))];
		rd_ns_q   <= node_stack[NIW'(nst_q - NW'(1))];
		rd_cn_q   <= call_node[NIW'(cst_q - NW'(2))];
		rd_ca_q   <= call_arc[NIW'(cst_q - NW'(2))];
		rd_cl_q   <= call_low[NIW'(cst_q - NW'(2))];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR; k_q <= '0; lst_q <= 1'b0; ovf_q <= 1'b0; conf_q <= 1'b0;
			n_q <= NW'(1); a_q <= '0; b_q <= '0; i_q <= '0; v_q <= '0; t_q <= '0;
			low_q <= '0; tm_q <= NW'(1); cc_q <= NW'(1); nst_q <= '0; cst_q <= '0;
			arc_cnt_q <= '0; ca_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (start) begin
						n_q <= neff; a_q <= ext_a; b_q <= ext_b; lst_q <= lst;
						k_q <= '0; i_q <= NW'(1); conf_q <= 1'b0;
						if (edge_ok && arc_cnt_q <= ALIM) state_q <= ST_ARCR;
						else begin
							if (edge_ok) ovf_q <= 1'b1;
							state_q <= lst ? ST_SCAN : ST_LOAD;
						end
					end
				end
				ST_ARCR: state_q <= ST_ARCW;
				ST_ARCW: begin
					arc_cnt_q <= arc_cnt_q + AW'(1);
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) state_q <= lst_q ? ST_SCAN : ST_LOAD;
					else state_q <= ST_ARCR;
				end
				ST_SCAN: begin
					if (i_q > two_n) begin i_q <= NW'(1); state_q <= ST_CHK; end
					else state_q <= ST_SCANR;
				end
				ST_SCANR: begin
					if (enter_root) begin
						nst_q <= nst_q + NW'(1); tm_q <= tm_q + NW'(1);
						v_q <= i_q; ca_q <= rd_lh_q; low_q <= tm_q;
						cst_q <= NW'(1);
						state_q <= ST_STEP;
					end else begin
						i_q <= i_q + NW'(1); state_q <= ST_SCAN;
					end
				end
				ST_STEP: state_q <= (ca_q != '0) ? ST_ARCD : ST_FIN;
				ST_ARCD: begin
					t_q <= rd_tgt_q; ca_q <= rd_lnk_q;
					state_q <= ST_TGT;
				end
				ST_TGT: begin
					// visited target lowers the link value, new one becomes the top
					if (tgt_ok && rd_vt_q != '0) begin
						if (rd_vt_q < low_q) low_q <= rd_vt_q;
					end else if (enter_child) begin
						nst_q <= nst_q + NW'(1); tm_q <= tm_q + NW'(1);
						cst_q <= cst_q + NW'(1);
						v_q <= t_q; ca_q <= rd_lh_q; low_q <= tm_q;
					end
					state_q <= ST_STEP;
				end
				ST_FIN: state_q <= (low_q == rd_vt_q) ? ST_POPR : ST_RET;
				ST_POPR: state_q <= ST_POPW;
				ST_POPW: begin
					nst_q <= nst_q - NW'(1);
					if (rd_ns_q != v_q && nst_q != NW'(1)) state_q <= ST_POPR;
					else begin
						cc_q <= cc_q + NW'(1); state_q <= ST_RET;
					end
				end
				ST_RET: begin
					cst_q <= cst_q - NW'(1);
					if (cst_q == NW'(1)) begin i_q <= i_q + NW'(1); state_q <= ST_SCAN; end
					else state_q <= ST_REST;
				end
				ST_REST: begin
					v_q <= rd_cn_q; ca_q <= rd_ca_q;
					low_q <= (low_q < rd_cl_q) ? low_q : rd_cl_q;
					state_q <= ST_STEP;
				end
				ST_CHK: state_q <= (i_q > n_q) ? ST_OUT : ST_CHKR;
				ST_CHKR: begin
					if (rd_cid_q == rd_cid2_q) conf_q <= 1'b1;
					i_q <= i_q + NW'(1); state_q <= ST_CHK;
				end
				ST_OUT: begin
					i_q <= '0; state_q <= ST_CLR;
				end
				ST_CLR: begin
					// clearing pass over node tables
					i_q <= i_q + NW'(1);
					if (i_q == NLAST) begin
						state_q <= ST_LOAD; arc_cnt_q <= '0; ovf_q <= 1'b0;
						tm_q <= NW'(1); cc_q <= NW'(1); nst_q <= '0; cst_q <= '0;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ src/tcc_out.sv @@
// Output register holding one result word until the receiver takes it.
`default_nettype none
module tcc_out import tcc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  tcc_status_t      status,
	output logic             full,
	output logic [7:0]       data,
	input  wire logic        take
);
	logic valid_q;
	logic [1:0] res_q;
	// Capture on done, release on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (status.done) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (status.done) res_q <= {status.overflow, status.conflict};
	end
	assign full = valid_q;
	assign data = {6'd0, res_q};
endmodule
`default_nettype wire

@@ src/two_coloring_check_by_scc.sv @@
// Top level: stream ports around the SCC engine and its result register.
// Two-coloring check of an undirected graph.
// s_axis carries one edge word per transfer; the word with tlast set closes
// the graph and starts the check. cfg_we/cfg_data set the vertex count; the
// user must set it only while nothing is in flight, the block does not
// enforce this. m_axis returns one word per graph. An edge word is taken in
// the handshake, then its four arcs are loaded, each by a list head read,
// then an arc and head write; s_axis_tready is low in between. A word
// without a loadable edge needs the handshake alone.
// The check scans each node, follows each arc of an entered node and pops
// each finished component; the compare pass then checks every vertex
// against its complement node, and the result word is registered from the
// done status. A clearing pass then runs over all 2*MAX_VERTICES+1 node
// table entries; the same pass runs after reset before the first word is taken.
// A stalled receiver holds the result word; after the clearing pass the next
// graph's edges are taken; a closing word waits until the result is taken.
`default_nettype none
module two_coloring_check_by_scc import tcc_pkg::*; #(
	parameter int MAX_VERTICES = 2048,
	parameter int MAX_EDGES = 16384
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // vertex_a, vertex_b
	input  wire logic        s_axis_tuser,  // edge_valid
	input  wire logic        s_axis_tlast,  // last_edge
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata   // conflict_found, edge_overflow
);
	logic [11:0] vcount_q;
	logic busy, full, acc;
	tcc_status_t st;

	// Vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= 12'd1;
		else if (cfg_we) vcount_q <= cfg_data;
	end

	assign s_axis_tready = !busy && !(full && s_axis_tlast);
	assign acc = s_axis_tvalid && s_axis_tready;

	tcc_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_eng (
		.clk(clk), .arst_n(arst_n), .start(acc),
		.va(s_axis_tdata[11:0]), .vb(s_axis_tdata[23:12]),
		.ev(s_axis_tuser), .lst(s_axis_tlast), .vcount(vcount_q),
		.busy(busy), .status(st)
	);

	tcc_out u_out (
		.clk(clk), .arst_n(arst_n), .status(st), .full(full),
		.data(m_axis_tdata), .take(m_axis_tready)
	);
	assign m_axis_tvalid = full;
endmodule
`default_nettype wire

@@ src/tcc_checker.sv @@
// Port-level checker for the two-coloring block, bound to the top level.
`default_nettype none
`include "two_coloring_check_by_scc_macros.svh"
module tcc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       s_axis_tlast,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);
	// Input side goes busy right after a closing word is taken
	`TCC_ASSERT_NEXT(a_last_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
	// Result held while stalled
	`TCC_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// Upper pad bits are zero
	`TCC_ASSERT_IMP(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0)
endmodule
bind two_coloring_check_by_scc tcc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
